@@ rtl/multi_waveform_sample_generator_defines.svh @@
// Assertion macros used by the checker in rtl/mwsg_checker.sv.
`ifndef MULTI_WAVEFORM_SAMPLE_GENERATOR_DEFINES_SVH
`define MULTI_WAVEFORM_SAMPLE_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MWSG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MWSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mwsg_pkg.sv @@
package mwsg_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int PHASE_BITS      = 32;
  localparam int ROM_N           = 1 << SINE_TABLE_BITS;
  localparam int ROM_DEPTH       = ROM_N + 1;
  localparam int ADDR_BITS       = SINE_TABLE_BITS + 1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic [2:0] WAVE_SINE     = 3'd0;
  localparam logic [2:0] WAVE_COSINE   = 3'd1;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
  localparam logic [2:0] WAVE_SAWTOOTH = 3'd3;
  localparam logic [2:0] WAVE_SQUARE   = 3'd4;

  localparam logic [2:0] REG_WAVE_SELECT  = 3'd0;
  localparam logic [2:0] REG_FREQ_WORD    = 3'd1;
  localparam logic [2:0] REG_PHASE_OFFSET = 3'd2;
  localparam logic [2:0] REG_AMPLITUDE    = 3'd3;
  localparam logic [2:0] REG_DC_OFFSET    = 3'd4;

  typedef struct packed {
    logic [2:0]          wave_select;
    logic [31:0]         freq_word;
    logic [31:0]         phase_offset;
    logic [14:0]         amplitude;
    logic signed [15:0]  dc_offset;
  } mwsg_cfg_t;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] addr;
    logic                 neg;
    logic [15:0]          u;
  } mwsg_ph_t;

  typedef struct packed {
    logic                valid;
    logic                is_sine;
    logic                neg;
    logic [15:0]         rom;
    logic signed [16:0]  alt;
  } mwsg_sh_t;

  // Quarter-wave entry: sin(i/N * pi/2) in Q15 from a Taylor series in Q30.
  function automatic logic [15:0] sine_entry(input int unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint          sum;
    x    = (longint'(i) * HALF_PI_Q30 + (longint'(ROM_N) >> 1)) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    sum  = longint'(x);
    term = ((x * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    r = (longint'(sum) + 16384) >> 15;
    if (r > 32768) begin
      r = 32768;
    end
    return r[15:0];
  endfunction

endpackage

@@ rtl/mwsg_cfg_regs.sv @@
module mwsg_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output mwsg_pkg::mwsg_cfg_t cfg
);
  import mwsg_pkg::*;

  mwsg_cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WAVE_SELECT:  regs.wave_select  <= cfg_data[2:0];
        REG_FREQ_WORD:    regs.freq_word    <= cfg_data;
        REG_PHASE_OFFSET: regs.phase_offset <= cfg_data;
        REG_AMPLITUDE:    regs.amplitude    <= cfg_data[14:0];
        REG_DC_OFFSET:    regs.dc_offset    <= $signed(cfg_data[15:0]);
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

@@ rtl/mwsg_phase.sv @@
module mwsg_phase (
  input  logic                clk,
  input  logic                rst,
  input  mwsg_pkg::mwsg_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         sample_time,
  input  logic                dn_ready,
  output mwsg_pkg::mwsg_ph_t  dn
);
  import mwsg_pkg::*;

  logic                  s1_valid;
  logic [PHASE_BITS-1:0] s1_prod;
  logic                  s2_valid;
  logic [ADDR_BITS-1:0]  s2_addr;
  logic                  s2_neg;
  logic [15:0]           s2_u;

  logic                       en1;
  logic                       en2;
  logic [PHASE_BITS-1:0]      prod_full;
  logic [PHASE_BITS-1:0]      phase;
  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [ADDR_BITS-1:0]       addr_next;

  assign en2      = !s2_valid || dn_ready;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  assign prod_full = sample_time * cfg.freq_word;

  // The cosine is the sine one quadrant later.
  assign phase = s1_prod + PHASE_BITS'(cfg.phase_offset);
  assign quad  = phase[PHASE_BITS-1 -: 2] + ((cfg.wave_select == WAVE_COSINE) ? 2'd1 : 2'd0);
  assign idx   = phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
  assign addr_next = quad[0] ? (ADDR_BITS'(ROM_N) - {1'b0, idx}) : {1'b0, idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= in_valid;
      end
      if (en2) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_prod <= prod_full;
    end
    if (en2) begin
      s2_addr <= addr_next;
      s2_neg  <= quad[1];
      s2_u    <= phase[PHASE_BITS-1 -: 16];
    end
  end

  assign dn = '{valid: s2_valid, addr: s2_addr, neg: s2_neg, u: s2_u};

endmodule

@@ rtl/mwsg_shape.sv @@
module mwsg_shape (
  input  logic                clk,
  input  logic                rst,
  input  mwsg_pkg::mwsg_cfg_t cfg,
  input  mwsg_pkg::mwsg_ph_t  up,
  output logic                up_ready,
  input  logic                dn_ready,
  output mwsg_pkg::mwsg_sh_t  dn
);
  import mwsg_pkg::*;

  logic [15:0] rom [ROM_DEPTH];

  logic               s3_valid;
  logic               s3_is_sine;
  logic               s3_neg;
  logic [15:0]        s3_rom;
  logic signed [16:0] s3_alt;

  logic               en3;
  logic               is_sine;
  logic signed [17:0] u_s;
  logic signed [17:0] u2;
  logic signed [17:0] alt_next;

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    localparam logic [15:0] Entry = sine_entry(g);
    assign rom[g] = Entry;
  end

  assign en3      = !s3_valid || dn_ready;
  assign up_ready = en3;

  assign is_sine = (cfg.wave_select == WAVE_SINE) || (cfg.wave_select == WAVE_COSINE);
  assign u_s     = $signed({2'b00, up.u});
  assign u2      = $signed({1'b0, up.u, 1'b0});

  always_comb begin
    unique case (cfg.wave_select)
      WAVE_TRIANGLE: alt_next = up.u[15] ? (18'sd98304 - u2) : (u2 - 18'sd32768);
      WAVE_SAWTOOTH: alt_next = u_s - 18'sd32768;
      WAVE_SQUARE:   alt_next = up.u[15] ? 18'sd32768 : -18'sd32768;
      default:       alt_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en3) begin
      s3_valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_rom     <= rom[up.addr];
      s3_neg     <= up.neg;
      s3_is_sine <= is_sine;
      s3_alt     <= alt_next[16:0];
    end
  end

  assign dn = '{valid: s3_valid, is_sine: s3_is_sine, neg: s3_neg, rom: s3_rom, alt: s3_alt};

endmodule

@@ rtl/mwsg_scale.sv @@
module mwsg_scale (
  input  logic                clk,
  input  logic                rst,
  input  mwsg_pkg::mwsg_cfg_t cfg,
  input  mwsg_pkg::mwsg_sh_t  up,
  output logic                up_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  sample_value,
  output logic                clipped
);
  import mwsg_pkg::*;

  logic               s4_valid;
  logic signed [31:0] s4_prod;

  logic               en4;
  logic               en5;
  logic signed [16:0] rom_s;
  logic signed [16:0] shape;
  logic signed [15:0] amp_s;
  logic signed [31:0] prod_full;
  logic signed [31:0] rounded;
  logic signed [17:0] sum;
  logic signed [15:0] value_next;
  logic               clip_next;

  assign en5      = !out_valid || out_ready;
  assign en4      = !s4_valid || en5;
  assign up_ready = en4;

  assign rom_s     = $signed({1'b0, up.rom});
  assign shape     = up.is_sine ? (up.neg ? -rom_s : rom_s) : up.alt;
  assign amp_s     = $signed({1'b0, cfg.amplitude});
  assign prod_full = 32'(amp_s) * 32'(shape);

  // Round half up to Q15, then add the offset in a word wide enough not to wrap.
  assign rounded = s4_prod + 32'sd16384;
  assign sum     = $signed({rounded[31], rounded[31:15]}) + $signed({{2{cfg.dc_offset[15]}},
                                                                     cfg.dc_offset});

  always_comb begin
    priority if (sum > 18'sd32767) begin
      value_next = 16'sh7FFF;
      clip_next  = 1'b1;
    end else if (sum < -18'sd32768) begin
      value_next = -16'sh8000;
      clip_next  = 1'b1;
    end else begin
      value_next = sum[15:0];
      clip_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en4) begin
        s4_valid <= up.valid;
      end
      if (en5) begin
        out_valid <= s4_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_prod <= prod_full;
    end
    if (en5) begin
      sample_value <= value_next;
      clipped      <= clip_next;
    end
  end

endmodule

@@ rtl/multi_waveform_sample_generator.sv @@
// Waveform generator: each word on the input carries a sample time and yields one word on
// the output, a signed 16-bit sample of a sine, cosine, triangle, sawtooth or square wave
// at phase (sample_time * freq_word + phase_offset), scaled by amplitude, shifted by
// dc_offset and saturated, with clipped set when saturation took place. A new word is
// taken every clock while out_ready does not stall the pipeline, and each passes through
// the phase multiplier, the phase add and quadrant fold, the registered read of the
// 1025-entry quarter-wave ROM, the amplitude multiplier, and the rounding and saturation
// stage that feeds the output register. Registers are to be written through cfg_we,
// cfg_index and cfg_data only while no word is in flight; the block does not enforce it.
module multi_waveform_sample_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        sample_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample_value,
  output logic               clipped
);
  import mwsg_pkg::*;

  mwsg_cfg_t cfg;
  mwsg_ph_t  ph;
  mwsg_sh_t  sh;
  logic      ph_ready;
  logic      sh_ready;

  mwsg_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mwsg_phase u_phase (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_time (sample_time),
    .dn_ready    (ph_ready),
    .dn          (ph)
  );

  mwsg_shape u_shape (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up       (ph),
    .up_ready (ph_ready),
    .dn_ready (sh_ready),
    .dn       (sh)
  );

  mwsg_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .up           (sh),
    .up_ready     (sh_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_value (sample_value),
    .clipped      (clipped)
  );

endmodule

@@ rtl/mwsg_checker.sv @@
`include "multi_waveform_sample_generator_defines.svh"

module mwsg_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [31:0]        sample_time,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] sample_value,
  input logic               clipped
);

  `MWSG_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(sample_time), "input word changed while stalled")

  `MWSG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_value) && $stable(clipped), "output word changed while stalled")

  `MWSG_ASSERT_NOW(a_clip_limit, out_valid && clipped, sample_value == 16'sh7FFF || sample_value == -16'sh8000, "clipped sample not at a limit")

  `MWSG_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with an empty output register")

endmodule

bind multi_waveform_sample_generator mwsg_checker u_checker (.*);

@@ tb/sv/mwsg_sample_checker.sv @@
module mwsg_sample_checker
  import mwsg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [31:0]        sample_time,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] sample_value,
  input  logic               clipped,
  output int                 fail_count,
  output int                 outstanding,
  output int                 checked_count
);

  typedef struct packed {
    logic signed [15:0] value;
    logic               clip;
  } sample_t;

  localparam logic [PHASE_BITS-1:0] QUARTER_CYCLE = 1 << (PHASE_BITS - 2);

  logic [15:0]        quarter_wave [ROM_DEPTH];
  logic [2:0]         wave_sel;
  logic [31:0]        freq;
  logic [31:0]        offset;
  logic [14:0]        amp;
  logic signed [15:0] dc;
  sample_t            expected_samples [$];

  function automatic logic [15:0] taylor_sine(input int unsigned idx);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned rounded;
    longint          acc;
    x    = (64'(idx) * HALF_PI_Q30 + 64'(ROM_N / 2)) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    rounded = (64'(acc) + 64'd16384) >> 15;
    if (rounded > 64'd32768) begin
      rounded = 64'd32768;
    end
    return rounded[15:0];
  endfunction

  function automatic int table_shape(input logic [PHASE_BITS-1:0] ph);
    logic [1:0]  quad;
    int unsigned idx;
    int          mag;
    quad = ph[PHASE_BITS-1 -: 2];
    idx  = ph[PHASE_BITS-3 -: SINE_TABLE_BITS];
    if (quad[0]) begin
      idx = ROM_N - idx;
    end
    mag = int'(quarter_wave[idx]);
    return quad[1] ? -mag : mag;
  endfunction

  function automatic sample_t predict_sample(input logic [31:0] t);
    logic [PHASE_BITS-1:0] ph;
    int                    u;
    int                    shape;
    longint                total;
    sample_t               s;
    ph = t * freq + offset;
    u  = int'(ph[PHASE_BITS-1 -: 16]);
    case (wave_sel)
      WAVE_SINE:     shape = table_shape(ph);
      WAVE_COSINE:   shape = table_shape(ph + QUARTER_CYCLE);
      WAVE_TRIANGLE: shape = (u < 32768) ? (2 * u - 32768) : (98304 - 2 * u);
      WAVE_SAWTOOTH: shape = u - 32768;
      WAVE_SQUARE:   shape = (u < 32768) ? -32768 : 32768;
      default:       shape = 0;
    endcase
    total = ((longint'(amp) * longint'(shape) + 64'sd16384) >>> 15) + longint'(dc);
    s.clip = 1'b1;
    if (total > 32767) begin
      s.value = 16'sh7FFF;
    end else if (total < -32768) begin
      s.value = 16'sh8000;
    end else begin
      s.value = total[15:0];
      s.clip  = 1'b0;
    end
    return s;
  endfunction

  initial begin
    for (int i = 0; i < ROM_DEPTH; i++) begin
      quarter_wave[i] = taylor_sine(i);
    end
  end

  always @(posedge clk) begin : watch
    sample_t want;
    if (rst) begin
      wave_sel = '0;
      freq     = '0;
      offset   = '0;
      amp      = '0;
      dc       = '0;
      expected_samples.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected output word: sample_value %0d, clipped %0b",
                 sample_value, clipped);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          checked_count++;
          if (sample_value !== want.value) begin
            $error("sample_value: expected %0d, actual %0d", want.value, sample_value);
            fail_count++;
          end
          if (clipped !== want.clip) begin
            $error("clipped: expected %0b, actual %0b", want.clip, clipped);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_WAVE_SELECT:  wave_sel = cfg_data[2:0];
          REG_FREQ_WORD:    freq     = cfg_data;
          REG_PHASE_OFFSET: offset   = cfg_data;
          REG_AMPLITUDE:    amp      = cfg_data[14:0];
          REG_DC_OFFSET:    dc       = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_samples.push_back(predict_sample(sample_time));
      end
    end
    outstanding = expected_samples.size();
  end

endmodule

@@ tb/sv/multi_waveform_sample_generator_tb.sv @@
module multi_waveform_sample_generator_tb;
  import mwsg_pkg::*;

  localparam int IDLE_LIMIT  = 20000;
  localparam int TOTAL_ITEMS = 1550;

  typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_PERIODIC} ready_mode_e;
  typedef enum {TIMES_STREAM, TIMES_SCATTER, TIMES_EDGES} time_pattern_e;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_we      = 1'b0;
  logic [2:0]         cfg_index   = '0;
  logic [31:0]        cfg_data    = '0;
  logic               in_valid    = 1'b0;
  logic [31:0]        sample_time = '0;
  logic               out_ready   = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic signed [15:0] sample_value;
  logic               clipped;

  int          fail_count;
  int          outstanding;
  int          checked_count;
  int          sent_count    = 0;
  int          setting_count = 0;
  int          burst_left    = 0;
  int          idle_cycles   = 0;
  int          ready_left    = 0;
  ready_mode_e ready_mode    = READY_ALWAYS;

  multi_waveform_sample_generator DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_time  (sample_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_value (sample_value),
    .clipped      (clipped)
  );

  mwsg_sample_checker sample_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample_time   (sample_time),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_value  (sample_value),
    .clipped       (clipped),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_left = $urandom_range(1, 60);
    end
    ready_left--;
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
      READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:      out_ready <= ((ready_left % 8) < 3);
    endcase
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [31:0] with_noise(input logic [31:0] value, input int width);
    logic [31:0] keep;
    keep = (width >= 32) ? '1 : ((32'd1 << width) - 32'd1);
    if ($urandom_range(0, 1) == 0) begin
      return value & keep;
    end
    return (value & keep) | ($urandom & ~keep);
  endfunction

  task automatic send_time(input logic [31:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    sample_time <= t;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [2:0] wave, input logic [31:0] freq,
                               input logic [31:0] offset, input logic [14:0] amp,
                               input logic signed [15:0] dc);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(3'(int'(REG_DC_OFFSET) + $urandom_range(1, 3)), $urandom);
    end
    write_reg(REG_WAVE_SELECT, with_noise(32'(wave), 3));
    write_reg(REG_FREQ_WORD, freq);
    write_reg(REG_PHASE_OFFSET, offset);
    write_reg(REG_AMPLITUDE, with_noise(32'(amp), 15));
    write_reg(REG_DC_OFFSET, with_noise(32'(dc), 16));
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  initial begin
    int            n;
    logic [2:0]    wave;
    logic [31:0]   freq;
    logic [31:0]   base;
    logic [31:0]   stride;
    logic [31:0]   t;
    logic [14:0]   amp;
    logic signed [15:0] dc;
    time_pattern_e pattern;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Registers still at their reset values: zero amplitude, zero offset.
    send_time(32'd0);
    send_time('1);

    // Sine across quadrant boundaries, full scale.
    load_settings(WAVE_SINE, 32'h0040_0000, 32'd0, 15'h7FFF, 16'sd0);
    send_time(32'd0);
    send_time(32'd128);
    send_time(32'd256);
    send_time(32'd512);
    send_time(32'd768);

    // Cosine with the largest offset, so that the positive peak saturates.
    load_settings(WAVE_COSINE, 32'h0040_0000, 32'd0, 15'h7FFF, 16'sh7FFF);
    send_time(32'd0);
    send_time(32'd512);

    // Triangle with the most negative offset, so that the trough saturates.
    load_settings(WAVE_TRIANGLE, 32'h0001_0000, 32'h8000_0000, 15'h7FFF, 16'sh8000);
    send_time(32'd0);
    send_time(32'd16384);
    send_time(32'd32768);
    send_time(32'd65535);

    load_settings(WAVE_SAWTOOTH, 32'd1, 32'hFFFF_FFFF, 15'h7FFF, 16'sd0);
    send_time(32'd0);
    send_time(32'd1);
    send_time(32'hFFFF_FFFF);

    load_settings(WAVE_SQUARE, 32'hFFFF_FFFF, 32'd0, 15'h7FFF, -16'sd1);
    send_time(32'd0);
    send_time(32'd1);
    send_time(32'h8000_0000);

    // Unused selectors give the offset alone.
    for (int w = int'(WAVE_SQUARE) + 1; w < 8; w++) begin
      load_settings(3'(w), $urandom, $urandom, 15'h7FFF, 16'sh8000);
      send_time($urandom);
    end

    while (sent_count < TOTAL_ITEMS) begin
      if ($urandom_range(0, 15) < 14) begin
        wave = 3'($urandom_range(WAVE_SINE, WAVE_SQUARE));
      end else begin
        wave = 3'($urandom_range(int'(WAVE_SQUARE) + 1, 7));
      end
      case ($urandom_range(0, 3))
        0:       freq = $urandom;
        1:       freq = $urandom_range(0, 65535);
        2:       freq = 32'd1 << $urandom_range(0, 31);
        default: freq = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
      endcase
      case ($urandom_range(0, 3))
        0:       amp = 15'd0;
        1:       amp = 15'h7FFF;
        default: amp = 15'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       dc = 16'sd0;
        1:       dc = ($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000;
        2:       dc = 16'($urandom_range(0, 4000) - 2000);
        default: dc = 16'($urandom);
      endcase
      load_settings(wave, freq, $urandom, amp, dc);

      n       = $urandom_range(10, 120);
      pattern = time_pattern_e'($urandom_range(0, 2));
      base    = $urandom;
      stride  = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(1, 3)) : $urandom;
      for (int i = 0; i < n && sent_count < TOTAL_ITEMS; i++) begin
        case (pattern)
          TIMES_STREAM:  t = base + 32'(i) * stride;
          TIMES_SCATTER: t = $urandom;
          default: begin
            if ($urandom_range(0, 3) == 0) begin
              t = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
            end else begin
              t = $urandom;
            end
          end
        endcase
        send_time(t);
      end
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Sent %0d sample times under %0d register settings; %0d samples checked.",
             sent_count, setting_count, checked_count);
    $display("All five shapes, the unused selectors and both saturation limits were driven.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/mwsg_pkg.sv
rtl/mwsg_cfg_regs.sv
rtl/mwsg_phase.sv
rtl/mwsg_shape.sv
rtl/mwsg_scale.sv
rtl/multi_waveform_sample_generator.sv
rtl/mwsg_checker.sv
tb/sv/mwsg_sample_checker.sv
tb/sv/multi_waveform_sample_generator_tb.sv
